>>> rtl/mct_pkg.sv
// Shared widths and command codes of the congruence transform block.
package mct_pkg;

    localparam int IDX_W  = 2;
    localparam int DATA_W = 32;
    localparam int ACC_W  = 48;

    typedef enum logic [1:0] {
        CMD_WRITE_A = 2'd0,
        CMD_WRITE_B = 2'd1,
        CMD_COMPUTE = 2'd2
    } t_cmd;

endpackage

>>> rtl/mct_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module mct_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 9
) (
    input  logic                                          i_clk,
    input  logic                                          i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                              i_wdata,
    input  logic                                          i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/matrix_congruence_transform_top.sv
// Top level of the congruence transform C = A * B * A^T on Q16.16 matrices.
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+-----------------------------------------
//  in      | input     | i_in_valid/o_in_stall | i_command, i_row_index, i_col_index,
//          |           |                      | i_element_value
//  out     | output    | o_out_valid/i_out_stall | o_result_row, o_result_col,
//          |           |                      | o_result_value, o_saturated, o_last
//
// A load transfer writes one element of A or B; out-of-range indices write nothing.
// A compute transfer issues DIM^4 triple-product terms, one a cycle unless the output stalls,
// through one shared multiply path; each element of C appears once its DIM^2 terms are summed.
// The input stalls while the terms of a compute are being issued.
// A stalled output freezes the whole term pipeline until the transfer completes.
// Reset is synchronous and active low; A and B hold no defined value until written.
module matrix_congruence_transform_top #(
    parameter int DIM = 3
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [mct_pkg::IDX_W-1:0]            i_command,
    input  logic [mct_pkg::IDX_W-1:0]            i_row_index,
    input  logic [mct_pkg::IDX_W-1:0]            i_col_index,
    input  logic signed [mct_pkg::DATA_W-1:0]    i_element_value,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [mct_pkg::IDX_W-1:0]            o_result_row,
    output logic [mct_pkg::IDX_W-1:0]            o_result_col,
    output logic signed [mct_pkg::DATA_W-1:0]    o_result_value,
    output logic                                 o_saturated,
    output logic                                 o_last
);

    localparam int CELLS = DIM * DIM;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int IW    = mct_pkg::IDX_W;
    localparam int FW    = 2 * IW;
    localparam int DW    = mct_pkg::DATA_W;
    localparam int AccW  = mct_pkg::ACC_W;
    localparam logic [IW-1:0] IDX_LAST = IW'(DIM - 1);
    localparam logic [FW-1:0] DIM_F    = FW'(DIM);
    localparam logic signed [AccW-1:0] ACC_MAX = {1'b0, {(AccW-1){1'b1}}};
    localparam logic signed [AccW-1:0] ACC_MIN = {1'b1, {(AccW-1){1'b0}}};
    localparam logic [63:0] Q_POS_LIMIT = 64'(ACC_MAX);
    localparam logic [63:0] Q_NEG_LIMIT = 64'(1) << (AccW - 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

    typedef struct packed {
        logic          valid;
        logic          first;
        logic          last_term;
        logic          last_el;
        logic [IW-1:0] row;
        logic [IW-1:0] col;
    } t_tag;

    t_state r_state, n_state;
    logic [IW-1:0] r_i, r_j, r_l, r_m;
    logic [IW-1:0] n_i, n_j, n_l, n_m;

    logic in_accept, advance, issue;
    logic write_ok, we_a, we_b;
    logic [FW-1:0] waddr_full, a_row_full, a_col_full, b_full;
    logic [DW-1:0] a_row_q, a_col_q, b_q;
    t_tag issue_tag;

    t_tag r_s1_tag, r_s2_tag, r_s3_tag, r_s4_tag;
    logic signed [63:0] r_p;
    logic [DW-1:0] r_c2;
    logic [63:0] r_lo;
    logic [62:0] r_hi;
    logic r_neg3;
    logic signed [AccW-1:0] r_term;
    logic r_tovf;

    logic [63:0] pm;
    logic [DW-1:0] cm;
    logic [63:0] rnd, q;
    logic q_ovf;
    logic [AccW-1:0] q_mag;
    logic signed [AccW-1:0] term;

    logic signed [AccW-1:0] r_acc, n_acc, acc_base;
    logic r_held, n_held, held_base;
    logic signed [AccW:0] sum;

    logic r_out_valid;
    logic [IW-1:0] r_out_row, r_out_col;
    logic signed [DW-1:0] r_out_value, out_value;
    logic r_out_sat, r_out_last, out_sat;

    assign in_accept = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign advance = !r_out_valid || !i_out_stall;
    assign issue = (r_state == S_RUN);

    assign write_ok = (i_row_index <= IDX_LAST) && (i_col_index <= IDX_LAST);
    assign we_a = in_accept && write_ok && (i_command == mct_pkg::CMD_WRITE_A);
    assign we_b = in_accept && write_ok && (i_command == mct_pkg::CMD_WRITE_B);
    assign waddr_full = FW'(i_row_index) * DIM_F + FW'(i_col_index);
    assign a_row_full = FW'(r_i) * DIM_F + FW'(r_m);
    assign a_col_full = FW'(r_j) * DIM_F + FW'(r_l);
    assign b_full     = FW'(r_m) * DIM_F + FW'(r_l);

    mct_ram #(.WIDTH(DW), .DEPTH(CELLS)) u_a_row (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (waddr_full[AW-1:0]),
        .i_wdata (i_element_value),
        .i_re    (advance),
        .i_raddr (a_row_full[AW-1:0]),
        .o_rdata (a_row_q)
    );

    mct_ram #(.WIDTH(DW), .DEPTH(CELLS)) u_a_col (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (waddr_full[AW-1:0]),
        .i_wdata (i_element_value),
        .i_re    (advance),
        .i_raddr (a_col_full[AW-1:0]),
        .o_rdata (a_col_q)
    );

    mct_ram #(.WIDTH(DW), .DEPTH(CELLS)) u_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (waddr_full[AW-1:0]),
        .i_wdata (i_element_value),
        .i_re    (advance),
        .i_raddr (b_full[AW-1:0]),
        .o_rdata (b_q)
    );

    always_comb begin
        issue_tag.valid     = issue;
        issue_tag.first     = (r_l == '0) && (r_m == '0);
        issue_tag.last_term = (r_l == IDX_LAST) && (r_m == IDX_LAST);
        issue_tag.last_el   = (r_i == IDX_LAST) && (r_j == IDX_LAST);
        issue_tag.row       = r_i;
        issue_tag.col       = r_j;
    end

    always_comb begin
        n_state = r_state;
        n_i = r_i;
        n_j = r_j;
        n_l = r_l;
        n_m = r_m;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept && (i_command == mct_pkg::CMD_COMPUTE)) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (advance) begin
                    if (r_m == IDX_LAST) begin
                        n_m = '0;
                        if (r_l == IDX_LAST) begin
                            n_l = '0;
                            if (r_j == IDX_LAST) begin
                                n_j = '0;
                                if (r_i == IDX_LAST) begin
                                    n_i = '0;
                                    n_state = S_IDLE;
                                end else begin
                                    n_i = r_i + 1'b1;
                                end
                            end else begin
                                n_j = r_j + 1'b1;
                            end
                        end else begin
                            n_l = r_l + 1'b1;
                        end
                    end else begin
                        n_m = r_m + 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_i <= '0;
            r_j <= '0;
            r_l <= '0;
            r_m <= '0;
        end else begin
            r_state <= n_state;
            r_i <= n_i;
            r_j <= n_j;
            r_l <= n_l;
            r_m <= n_m;
        end
    end

    always_comb begin
        pm = r_p[63] ? 64'(-r_p) : 64'(r_p);
        cm = r_c2[DW-1] ? DW'(-r_c2) : r_c2;
    end

    always_comb begin
        rnd   = r_lo + 64'h0000_0000_8000_0000;
        q     = {1'b0, r_hi} + {32'd0, rnd[63:32]};
        q_ovf = r_neg3 ? (q > Q_NEG_LIMIT) : (q > Q_POS_LIMIT);
        q_mag = q[AccW-1:0];
        if (q_ovf) begin
            term = r_neg3 ? ACC_MIN : ACC_MAX;
        end else begin
            term = r_neg3 ? AccW'(-q_mag) : AccW'(q_mag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_tag <= '0;
            r_s2_tag <= '0;
            r_s3_tag <= '0;
            r_s4_tag <= '0;
        end else if (advance) begin
            r_s1_tag <= issue_tag;
            r_s2_tag <= r_s1_tag;
            r_s3_tag <= r_s2_tag;
            r_s4_tag <= r_s3_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_p    <= $signed(a_row_q) * $signed(b_q);
            r_c2   <= a_col_q;
            r_lo   <= pm[31:0] * 64'(cm);
            r_hi   <= 63'(pm[62:32]) * 63'(cm);
            r_neg3 <= r_p[63] ^ r_c2[DW-1];
            r_term <= term;
            r_tovf <= q_ovf;
        end
    end

    always_comb begin
        acc_base  = r_s4_tag.first ? '0 : r_acc;
        held_base = r_s4_tag.first ? 1'b0 : r_held;
        sum       = {acc_base[AccW-1], acc_base} + {r_term[AccW-1], r_term};
        n_acc     = acc_base;
        n_held    = held_base;
        priority if (held_base) begin
            n_acc = acc_base;
        end else if (r_tovf) begin
            n_acc  = r_term;
            n_held = 1'b1;
        end else if (sum[AccW] != sum[AccW-1]) begin
            n_acc  = sum[AccW] ? ACC_MIN : ACC_MAX;
            n_held = 1'b1;
        end else begin
            n_acc = sum[AccW-1:0];
        end
    end

    always_comb begin
        if (n_acc[AccW-1:DW-1] == '0 || n_acc[AccW-1:DW-1] == '1) begin
            out_value = n_acc[DW-1:0];
            out_sat   = 1'b0;
        end else begin
            out_value = n_acc[AccW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
            out_sat   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_held <= 1'b0;
        end else if (advance && r_s4_tag.valid) begin
            r_acc  <= n_acc;
            r_held <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_s4_tag.valid && r_s4_tag.last_term;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_s4_tag.valid && r_s4_tag.last_term) begin
            r_out_row   <= r_s4_tag.row;
            r_out_col   <= r_s4_tag.col;
            r_out_value <= out_value;
            r_out_sat   <= out_sat;
            r_out_last  <= r_s4_tag.last_el;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_row   = r_out_row;
    assign o_result_col   = r_out_col;
    assign o_result_value = r_out_value;
    assign o_saturated    = r_out_sat;
    assign o_last         = r_out_last;

endmodule

>>> rtl/mct_checker.sv
// Port-level assertions for the congruence transform top level, with its bind statement.
module mct_checker #(
    parameter int DIM = 3
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic [mct_pkg::IDX_W-1:0]         o_result_row,
    input logic [mct_pkg::IDX_W-1:0]         o_result_col,
    input logic signed [mct_pkg::DATA_W-1:0] o_result_value,
    input logic                              o_saturated,
    input logic                              o_last
);

    localparam int IW = mct_pkg::IDX_W;
    localparam int DW = mct_pkg::DATA_W;
    localparam logic [IW-1:0] IDX_LAST = IW'(DIM - 1);
    localparam logic [DW-1:0] VAL_MAX  = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] VAL_MIN  = {1'b1, {(DW-1){1'b0}}};

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_result_value)
            && $stable(o_result_row) && $stable(o_result_col) && $stable(o_last))
        else $error("stalled result transfer changed");

    a_last_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last |-> (o_result_row == IDX_LAST) && (o_result_col == IDX_LAST))
        else $error("last flag on wrong element");

    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_saturated |-> (o_result_value == VAL_MAX) || (o_result_value == VAL_MIN))
        else $error("saturated result not at a limit");

endmodule

bind matrix_congruence_transform_top mct_checker #(.DIM(DIM)) u_mct_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_result_row   (o_result_row),
    .o_result_col   (o_result_col),
    .o_result_value (o_result_value),
    .o_saturated    (o_saturated),
    .o_last         (o_last)
);
